/* hdl/acss_pkg.sv */
// ----------------------------------------------------------------------------
// acss_pkg: shared types and constants of the scan sequencer
// Payload words of the command, result and configuration channels, the
// operation codes and the configuration register indexes.
// ----------------------------------------------------------------------------
package acss_pkg;

  // schedule size and fixed field widths
  localparam int DEFAULT_SLOTS = 4;
  localparam int CHAN_REGS     = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCHEDULE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT0_CHANNEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT1_CHANNEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT2_CHANNEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT3_CHANNEL   = 3'd4;

  // reset value of the schedule length
  localparam logic [2:0] LENGTH_RESET = 3'd4;

  // operation codes
  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_RUN    = 2'd1,
    OP_SINGLE = 2'd2,
    OP_DONE   = 2'd3
  } op_t;

  // command word
  typedef struct packed {
    op_t        op;
    logic [7:0] sample_count;
    logic [1:0] single_channel;
    logic [7:0] conv_data;
  } cmd_t;

  // result word
  typedef struct packed {
    logic       start_conversion;
    logic [1:0] channel_select;
    logic       result_written;
    logic [1:0] result_slot;
    logic [7:0] result_value;
    logic       single_ready;
    logic [7:0] samples_left;
    logic       sequencing_on;
  } res_t;

  // configuration write word
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  // schedule setup handed from the register file to the engine
  typedef struct packed {
    logic [2:0]                 schedule_length;
    logic [CHAN_REGS-1:0][1:0]  slot_channel;
  } sched_cfg_t;

endpackage

/* hdl/acss_chan_if.sv */
// ----------------------------------------------------------------------------
// acss_chan_if: valid/ready channel
// Carries one payload word per handshake; source drives valid and data,
// sink drives ready.
// ----------------------------------------------------------------------------
interface acss_chan_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* hdl/acss_cfg_regs.sv */
// ----------------------------------------------------------------------------
// acss_cfg_regs: schedule configuration registers
// Holds the schedule length and the four slot channel numbers; writes are
// always accepted, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module acss_cfg_regs
  import acss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  acss_chan_if.sink    cfg,
  output sched_cfg_t   sched
);

  sched_cfg_t regs;

  assign cfg.ready = 1'b1;
  assign sched     = regs;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.schedule_length <= LENGTH_RESET;
      for (int k = 0; k < CHAN_REGS; k++) begin
        regs.slot_channel[k] <= 2'(k);
      end
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        REG_SCHEDULE_LENGTH: regs.schedule_length <= cfg.data.value;
        REG_SLOT0_CHANNEL:   regs.slot_channel[0] <= cfg.data.value[1:0];
        REG_SLOT1_CHANNEL:   regs.slot_channel[1] <= cfg.data.value[1:0];
        REG_SLOT2_CHANNEL:   regs.slot_channel[2] <= cfg.data.value[1:0];
        REG_SLOT3_CHANNEL:   regs.slot_channel[3] <= cfg.data.value[1:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/acss_engine.sv */
// ----------------------------------------------------------------------------
// acss_engine: command register, sequencer state and result register
// One command word per cycle, unless results back up, is decoded against the
// slot index, sample count and enable flag; results land in an output register.
// ----------------------------------------------------------------------------
module acss_engine
  import acss_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  sched_cfg_t  sched,
  acss_chan_if.sink   cmd,
  acss_chan_if.source res
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // command register
  logic       cmd_vld;
  cmd_t       cmd_reg;
  // result register
  logic       res_vld;
  res_t       res_reg;
  // sequencer state
  logic [IDX_W-1:0] slot_index;
  logic [7:0]       pending_count;
  logic             sequence_enable;

  logic [IDX_W-1:0] slot_index_next;
  logic [7:0]       pending_count_next;
  logic             sequence_enable_next;
  res_t             res_next;
  logic [4:0]       cur_slot;
  logic [4:0]       nxt_slot;
  logic             adv;

  // channel of a slot: slots past the channel registers use their low two bits
  function automatic logic [1:0] chan_of(input logic [IDX_W-1:0] s,
                                         input sched_cfg_t cfg_in);
    logic [4:0] s_ext;
    s_ext = 5'(s);
    if (s_ext < 5'(CHAN_REGS)) begin
      return cfg_in.slot_channel[s_ext[1:0]];
    end
    return s_ext[1:0];
  endfunction

  // handshake: the command stage moves when the result register frees up
  assign adv       = cmd_vld && (!res_vld || res.ready);
  assign cmd.ready = !cmd_vld || adv;
  assign res.valid = res_vld;
  assign res.data  = res_reg;

  // command decode and state update
  always_comb begin
    slot_index_next      = slot_index;
    pending_count_next   = pending_count;
    sequence_enable_next = sequence_enable;
    res_next             = '0;
    cur_slot             = 5'(slot_index);
    nxt_slot             = cur_slot + 5'd1;
    unique case (cmd_reg.op)
      OP_INIT: begin
        slot_index_next      = '0;
        sequence_enable_next = 1'b1;
      end
      OP_RUN: begin
        pending_count_next       = cmd_reg.sample_count;
        res_next.start_conversion = 1'b1;
        res_next.channel_select   = chan_of(slot_index, sched);
      end
      OP_SINGLE: begin
        sequence_enable_next      = 1'b0;
        res_next.start_conversion = 1'b1;
        res_next.channel_select   = cmd_reg.single_channel;
      end
      OP_DONE: begin
        res_next.result_value = cmd_reg.conv_data;
        if (sequence_enable) begin
          res_next.result_written = 1'b1;
          res_next.result_slot    = cur_slot[1:0];
          pending_count_next      = pending_count - 8'd1;
          if (pending_count_next != 8'd0) begin
            // wrap at the schedule length or past the last slot
            if (nxt_slot == {2'b00, sched.schedule_length} || nxt_slot >= 5'(SLOTS)) begin
              nxt_slot = '0;
            end
            slot_index_next           = nxt_slot[IDX_W-1:0];
            res_next.start_conversion = 1'b1;
            res_next.channel_select   = chan_of(slot_index_next, sched);
          end
        end else begin
          res_next.single_ready = 1'b1;
        end
      end
    endcase
    res_next.samples_left  = pending_count_next;
    res_next.sequencing_on = sequence_enable_next;
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
    end else if (cmd.ready) begin
      cmd_vld <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_reg <= cmd.data;
    end
  end

  // sequencer state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index      <= '0;
      pending_count   <= '0;
      sequence_enable <= 1'b0;
      res_vld         <= 1'b0;
    end else begin
      if (adv) begin
        slot_index      <= slot_index_next;
        pending_count   <= pending_count_next;
        sequence_enable <= sequence_enable_next;
        res_vld         <= 1'b1;
      end else if (res.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_reg <= res_next;
    end
  end

endmodule

/* hdl/adc_channel_scan_sequencer.sv */
// ----------------------------------------------------------------------------
// adc_channel_scan_sequencer: round-robin ADC scan sequencer
// Walks a configurable schedule of channel slots on conversion-done words
// and reports one result word per command word.
// ----------------------------------------------------------------------------
// order: the command register holds a taken command word, then the result
//   register takes its result word and raises result valid; an untaken full
//   result register holds the command register back
// throughput: one command word per cycle unless results back up; the
//   combinational decode on the slot index and sample count sets this rate
// reset: slot index, sample count and enable clear; schedule length 4, slot k
//   converts channel k; both registers come up empty
module adc_channel_scan_sequencer
  import acss_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  acss_chan_if.sink   cmd,
  acss_chan_if.source res,
  acss_chan_if.sink   cfg
);

  sched_cfg_t sched;

  // schedule configuration
  acss_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .sched (sched)
  );

  // sequencer datapath
  acss_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .sched (sched),
    .cmd   (cmd),
    .res   (res)
  );

  // stored data only while sequencing stays enabled
  a_written_needs_seq: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.result_written |-> res.data.sequencing_on)
    else $error("result stored while sequencing off");

  // a word is either stored or reported as single, never both
  a_written_xor_single: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.data.result_written && res.data.single_ready))
    else $error("stored and single result in one word");

  // no channel select without a start
  a_sel_idle_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.data.start_conversion |-> res.data.channel_select == 2'd0)
    else $error("channel select without conversion start");

  // the schedule only chains while samples remain
  a_chain_has_samples: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.result_written && res.data.start_conversion
      |-> res.data.samples_left != 8'd0)
    else $error("next conversion started with no samples left");

endmodule
